// ===== rtl/jsv_pkg.sv =====
// jsv_pkg: types, scanner state codes and literal tables for the json syntax validator
// no dependencies; used by json_syntax_validator
`default_nettype none

package jsv_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       done_res;
  } out_word_t;

  localparam logic [1:0] VERDICT_PENDING = 2'd0;
  localparam logic [1:0] VERDICT_ACCEPT  = 2'd1;
  localparam logic [1:0] VERDICT_REJECT  = 2'd2;

  localparam logic [6:0] NEST_RESET = 7'd64;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  // scanner states
  localparam logic [4:0] L_VALUE     = 5'd0;
  localparam logic [4:0] L_ARR_FIRST = 5'd1;
  localparam logic [4:0] L_OBJ_FIRST = 5'd2;
  localparam logic [4:0] L_OBJ_KEY   = 5'd3;
  localparam logic [4:0] L_COLON     = 5'd4;
  localparam logic [4:0] L_AFTER     = 5'd5;
  localparam logic [4:0] L_TRAIL     = 5'd6;
  localparam logic [4:0] L_STR       = 5'd7;
  localparam logic [4:0] L_ESC       = 5'd8;
  localparam logic [4:0] L_HEX       = 5'd9;
  localparam logic [4:0] L_KSTR      = 5'd10;
  localparam logic [4:0] L_KESC      = 5'd11;
  localparam logic [4:0] L_KHEX      = 5'd12;
  localparam logic [4:0] L_NMINUS    = 5'd13;
  localparam logic [4:0] L_NZERO     = 5'd14;
  localparam logic [4:0] L_NINT      = 5'd15;
  localparam logic [4:0] L_NDOT      = 5'd16;
  localparam logic [4:0] L_NFRAC     = 5'd17;
  localparam logic [4:0] L_NE        = 5'd18;
  localparam logic [4:0] L_NESIGN    = 5'd19;
  localparam logic [4:0] L_NEXP      = 5'd20;
  localparam logic [4:0] L_LIT_T     = 5'd21;
  localparam logic [4:0] L_LIT_F     = 5'd22;
  localparam logic [4:0] L_LIT_N     = 5'd23;

  // literal kinds: 0 true, 1 false, 2 null
  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    logic [2:0] len;
    case (kind)
      2'd1:    len = 3'd5;
      2'd0,
      2'd2:    len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (kind)
      2'd0: begin
        case (pos)
          3'd0:    ch = "t";
          3'd1:    ch = "r";
          3'd2:    ch = "u";
          3'd3:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0:    ch = "f";
          3'd1:    ch = "a";
          3'd2:    ch = "l";
          3'd3:    ch = "s";
          3'd4:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0:    ch = "n";
          3'd1:    ch = "u";
          3'd2:    ch = "l";
          3'd3:    ch = "l";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/json_syntax_validator.sv =====
// json_syntax_validator: streaming json well-formedness checker, one byte per word
// depends on jsv_pkg for word types, scanner state codes and literal tables
`default_nettype none

// the result for a byte is registered at the edge that accepts it, into q0 when q0 is
// empty or drained in that cycle, else into q1; one byte per cycle while in_stall is low
// a two-entry output buffer keeps input flowing while one result waits
// the container stack is a memory with a registered top-of-stack read
// rst_n (sync, active low) clears the scan state, the buffer and sets max_nesting to 64;
// stack contents are only read after being written, so they need no clearing
module json_syntax_validator #(
  parameter int MAX_DEPTH = 64
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire jsv_pkg::in_word_t in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output jsv_pkg::out_word_t  out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [6:0]          cfg_data
);

  localparam int DW = $clog2(MAX_DEPTH + 2);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH + 1) : 1;
  localparam int CW = (DW > 7) ? DW : 7;

  // configuration
  logic [6:0] max_nest_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_nest_r <= jsv_pkg::NEST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_nest_r <= cfg_data;
    end
  end

  // scan state
  logic [4:0]    st_r,    st_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [1:0]    hex_r,   hex_nxt;
  logic [2:0]    lit_r,   lit_nxt;
  logic          err_r,   err_nxt;

  logic [4:0]    st_n;
  logic [DW-1:0] depth_n;
  logic [1:0]    hex_n;
  logic [2:0]    lit_n;
  logic          err_n;

  // container stack, 1 = object
  logic          stack_mem [MAX_DEPTH+1];
  logic          top_r;
  logic [AW-1:0] rd_addr;
  logic          push;
  logic          push_bit;

  logic acc;
  assign acc = in_valid && !in_stall;

  logic [7:0] b;
  logic       ws, dig, hexd, ech;
  assign b    = in_data.byte_in;
  assign ws   = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  assign dig  = (b >= "0") && (b <= "9");
  assign hexd = dig || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  assign ech  = (b == "e") || (b == "E");

  logic top_obj;
  assign top_obj = (depth_r != '0) && top_r;

  // value start decode
  logic [CW-1:0] limit;
  logic          sv_cls, sv_ok, sv_push, sv_lit;
  logic [4:0]    sv_st;

  always_comb begin
    if (CW'(max_nest_r) < CW'(MAX_DEPTH)) limit = CW'(max_nest_r);
    else                                  limit = CW'(MAX_DEPTH);
    sv_cls  = 1'b1;
    sv_push = 1'b0;
    sv_lit  = 1'b0;
    sv_st   = jsv_pkg::L_VALUE;
    if (b == "{") begin
      sv_st   = jsv_pkg::L_OBJ_FIRST;
      sv_push = 1'b1;
    end else if (b == "[") begin
      sv_st   = jsv_pkg::L_ARR_FIRST;
      sv_push = 1'b1;
    end else if (b == "\"") begin
      sv_st = jsv_pkg::L_STR;
    end else if (b == "t") begin
      sv_st  = jsv_pkg::L_LIT_T;
      sv_lit = 1'b1;
    end else if (b == "f") begin
      sv_st  = jsv_pkg::L_LIT_F;
      sv_lit = 1'b1;
    end else if (b == "n") begin
      sv_st  = jsv_pkg::L_LIT_N;
      sv_lit = 1'b1;
    end else if (b == "-") begin
      sv_st = jsv_pkg::L_NMINUS;
    end else if (b == "0") begin
      sv_st = jsv_pkg::L_NZERO;
    end else if (dig) begin
      sv_st = jsv_pkg::L_NINT;
    end else begin
      sv_cls = 1'b0;
    end
    sv_ok = sv_cls && (CW'(depth_r) <= limit);
  end

  // byte scanner
  logic [4:0] cur;
  logic [4:0] fin_st;
  logic       go, bad, do_sv, do_close, key;
  logic [1:0] kind;

  assign fin_st = (depth_r == '0) ? jsv_pkg::L_TRAIL : jsv_pkg::L_AFTER;
  assign kind   = 2'(st_r - jsv_pkg::L_LIT_T);

  always_comb begin
    st_n     = st_r;
    depth_n  = depth_r;
    hex_n    = hex_r;
    lit_n    = lit_r;
    err_n    = err_r;
    push     = 1'b0;
    push_bit = (b == "{");
    cur      = st_r;
    go       = 1'b1;
    bad      = 1'b0;
    do_sv    = 1'b0;
    do_close = 1'b0;
    key      = 1'b0;
    if (!err_r) begin
      // number tail: consume, fail, or end and hand the byte to the context
      case (st_r) inside
        jsv_pkg::L_NMINUS: begin
          go = 1'b0;
          if (b == "0")  st_n = jsv_pkg::L_NZERO;
          else if (dig)  st_n = jsv_pkg::L_NINT;
          else           bad  = 1'b1;
        end
        jsv_pkg::L_NZERO, jsv_pkg::L_NINT: begin
          go = 1'b0;
          if (dig) begin
            if (st_r == jsv_pkg::L_NZERO) bad = 1'b1;
          end else if (b == ".") begin
            st_n = jsv_pkg::L_NDOT;
          end else if (ech) begin
            st_n = jsv_pkg::L_NE;
          end else begin
            go  = 1'b1;
            cur = fin_st;
          end
        end
        jsv_pkg::L_NDOT: begin
          go = 1'b0;
          if (dig) st_n = jsv_pkg::L_NFRAC;
          else     bad  = 1'b1;
        end
        jsv_pkg::L_NFRAC: begin
          go = 1'b0;
          if (ech) begin
            st_n = jsv_pkg::L_NE;
          end else if (!dig) begin
            go  = 1'b1;
            cur = fin_st;
          end
        end
        jsv_pkg::L_NE: begin
          go = 1'b0;
          if (b == "+" || b == "-") st_n = jsv_pkg::L_NESIGN;
          else if (dig)             st_n = jsv_pkg::L_NEXP;
          else                      bad  = 1'b1;
        end
        jsv_pkg::L_NESIGN: begin
          go = 1'b0;
          if (dig) st_n = jsv_pkg::L_NEXP;
          else     bad  = 1'b1;
        end
        jsv_pkg::L_NEXP: begin
          go = 1'b0;
          if (!dig) begin
            go  = 1'b1;
            cur = fin_st;
          end
        end
        default: go = 1'b1;
      endcase

      if (go) begin
        st_n = cur;
        key  = (cur == jsv_pkg::L_KSTR) || (cur == jsv_pkg::L_KESC) ||
               (cur == jsv_pkg::L_KHEX);
        unique case (cur) inside
          jsv_pkg::L_VALUE: begin
            if (!ws) do_sv = 1'b1;
          end
          jsv_pkg::L_ARR_FIRST: begin
            if (b == "]")  do_close = 1'b1;
            else if (!ws)  do_sv    = 1'b1;
          end
          jsv_pkg::L_OBJ_FIRST, jsv_pkg::L_OBJ_KEY: begin
            if (ws) begin
            end else if (b == "}" && cur == jsv_pkg::L_OBJ_FIRST) begin
              do_close = 1'b1;
            end else if (b == "\"") begin
              st_n = jsv_pkg::L_KSTR;
            end else begin
              bad = 1'b1;
            end
          end
          jsv_pkg::L_COLON: begin
            if (b == ":")  st_n = jsv_pkg::L_VALUE;
            else if (!ws)  bad  = 1'b1;
          end
          jsv_pkg::L_AFTER: begin
            if (ws) begin
            end else if (depth_r == '0) begin
              bad = 1'b1;
            end else if (b == ",") begin
              st_n = top_obj ? jsv_pkg::L_OBJ_KEY : jsv_pkg::L_VALUE;
            end else if ((b == "}" && top_obj) || (b == "]" && !top_obj)) begin
              do_close = 1'b1;
            end else begin
              bad = 1'b1;
            end
          end
          jsv_pkg::L_TRAIL: begin
            if (!ws) bad = 1'b1;
          end
          jsv_pkg::L_STR, jsv_pkg::L_KSTR: begin
            if (b == "\"")                  st_n = key ? jsv_pkg::L_COLON : fin_st;
            else if (b < jsv_pkg::CTRL_LIMIT) bad = 1'b1;
            else if (b == "\\")             st_n = key ? jsv_pkg::L_KESC : jsv_pkg::L_ESC;
          end
          jsv_pkg::L_ESC, jsv_pkg::L_KESC: begin
            if (b == "u") begin
              hex_n = 2'd0;
              st_n  = key ? jsv_pkg::L_KHEX : jsv_pkg::L_HEX;
            end else if (b == "\"" || b == "\\" || b == "/" || b == "b" ||
                         b == "f" || b == "n" || b == "r" || b == "t") begin
              st_n = key ? jsv_pkg::L_KSTR : jsv_pkg::L_STR;
            end else begin
              bad = 1'b1;
            end
          end
          jsv_pkg::L_HEX, jsv_pkg::L_KHEX: begin
            if (!hexd) begin
              bad = 1'b1;
            end else if (hex_r == 2'd3) begin
              hex_n = 2'd0;
              st_n  = key ? jsv_pkg::L_KSTR : jsv_pkg::L_STR;
            end else begin
              hex_n = hex_r + 2'd1;
            end
          end
          jsv_pkg::L_LIT_T, jsv_pkg::L_LIT_F, jsv_pkg::L_LIT_N: begin
            if (kind > 2'd2 || lit_r >= jsv_pkg::lit_len(kind) ||
                b != jsv_pkg::lit_char(kind, lit_r)) begin
              bad = 1'b1;
            end else if (lit_r + 3'd1 == jsv_pkg::lit_len(kind)) begin
              lit_n = 3'd0;
              st_n  = fin_st;
            end else begin
              lit_n = lit_r + 3'd1;
            end
          end
          default: bad = 1'b1;
        endcase

        if (do_sv) begin
          if (sv_ok) begin
            st_n = sv_st;
            if (sv_lit) lit_n = 3'd1;
            if (sv_push) begin
              push    = 1'b1;
              depth_n = depth_r + DW'(1);
            end
          end else begin
            bad = 1'b1;
          end
        end

        if (do_close) begin
          if (depth_r == '0) begin
            bad = 1'b1;
          end else begin
            depth_n = depth_r - DW'(1);
            st_n    = (depth_r == DW'(1)) ? jsv_pkg::L_TRAIL : jsv_pkg::L_AFTER;
          end
        end
      end
      if (bad) err_n = 1'b1;
    end
  end

  // result for this byte
  jsv_pkg::out_word_t res;
  logic               doc_ok;

  always_comb begin
    doc_ok = !err_n &&
             (st_n == jsv_pkg::L_TRAIL ||
              (depth_n == '0 &&
               (st_n == jsv_pkg::L_NZERO || st_n == jsv_pkg::L_NINT ||
                st_n == jsv_pkg::L_NFRAC || st_n == jsv_pkg::L_NEXP)));
    if (in_data.last_byte) begin
      res.verdict  = doc_ok ? jsv_pkg::VERDICT_ACCEPT : jsv_pkg::VERDICT_REJECT;
      res.done_res = 1'b1;
    end else begin
      res.verdict  = err_n ? jsv_pkg::VERDICT_REJECT : jsv_pkg::VERDICT_PENDING;
      res.done_res = 1'b0;
    end
  end

  // next scan state; the last byte returns everything to the document start
  always_comb begin
    st_nxt    = st_r;
    depth_nxt = depth_r;
    hex_nxt   = hex_r;
    lit_nxt   = lit_r;
    err_nxt   = err_r;
    if (acc) begin
      if (in_data.last_byte) begin
        st_nxt    = jsv_pkg::L_VALUE;
        depth_nxt = '0;
        hex_nxt   = 2'd0;
        lit_nxt   = 3'd0;
        err_nxt   = 1'b0;
      end else begin
        st_nxt    = st_n;
        depth_nxt = depth_n;
        hex_nxt   = hex_n;
        lit_nxt   = lit_n;
        err_nxt   = err_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= jsv_pkg::L_VALUE;
      depth_r <= '0;
      hex_r   <= 2'd0;
      lit_r   <= 3'd0;
      err_r   <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      depth_r <= depth_nxt;
      hex_r   <= hex_nxt;
      lit_r   <= lit_nxt;
      err_r   <= err_nxt;
    end
  end

  // stack: write at depth on push, read the next top-of-stack into top_r
  assign rd_addr = (depth_nxt == '0) ? '0 : AW'(depth_nxt - DW'(1));

  always_ff @(posedge clk) begin
    if (acc && push) begin
      stack_mem[AW'(depth_r)] <= push_bit;
    end
  end

  // a push makes the written bit the new top, so bypass the memory
  always_ff @(posedge clk) begin
    if (acc && push) top_r <= push_bit;
    else             top_r <= stack_mem[rd_addr];
  end

  // two-entry output buffer
  jsv_pkg::out_word_t q0_r, q1_r;
  logic               q0_vld_r, q1_vld_r;
  logic               take;

  assign take      = q0_vld_r && !out_stall;
  assign in_stall  = q1_vld_r;
  assign out_valid = q0_vld_r;
  assign out_data  = q0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q0_vld_r <= 1'b0;
      q1_vld_r <= 1'b0;
    end else if (take) begin
      if (q1_vld_r) begin
        q1_vld_r <= 1'b0;
      end else if (!acc) begin
        q0_vld_r <= 1'b0;
      end
    end else if (acc) begin
      if (!q0_vld_r) q0_vld_r <= 1'b1;
      else           q1_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (q1_vld_r) q0_r <= q1_r;
      else if (acc) q0_r <= res;
    end else if (acc) begin
      if (!q0_vld_r) q0_r <= res;
      else           q1_r <= res;
    end
  end

endmodule

`default_nettype wire
